// File: rtl/lapedge_pkg.sv
// Shared types, constants and helpers of the 3x3 Laplacian edge filter.
package lapedge_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;

  localparam int CFG_W = 12;
  localparam int ROW_W = 12;
  localparam int PIX_W = 8;
  localparam int SUM_W = PIX_W + 3;

  localparam logic [ROW_W-1:0] ROW_SAT      = '1;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic MODE_PAD = 1'b1;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic row_lo;
    logic row_hi;
    logic col_lo;
    logic col_hi;
  } class_t;

  typedef struct packed {
    col_t left;
    col_t center;
    col_t right;
    logic last;
    logic row_lo;
    logic row_hi;
    logic col_lo;
    logic col_hi;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] val,
                                                 input int max_dim);
    logic [CFG_W-1:0] res;
    res = val;
    if (val == '0) begin
      res = CFG_W'(1);
    end else if (int'(val) > max_dim) begin
      res = CFG_W'(max_dim);
    end
    return res;
  endfunction

endpackage

// File: rtl/lapedge_if.sv
// Valid/ready stream interfaces for pixel requests and edge results.
interface lapedge_in_if;
  logic                valid;
  logic                ready;
  logic                mode;
  lapedge_pkg::pix_t   pixel;

  modport source(output valid, output mode, output pixel, input ready);
  modport sink(input valid, input mode, input pixel, output ready);
endinterface

interface lapedge_out_if;
  logic                valid;
  logic                ready;
  lapedge_pkg::pix_t   edge_value;
  logic                last_pixel;

  modport source(output valid, output edge_value, output last_pixel, input ready);
  modport sink(input valid, input edge_value, input last_pixel, output ready);
endinterface

// File: rtl/lapedge_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
module lapedge_ram #(
  parameter int WIDTH  = 2 * lapedge_pkg::PIX_W,
  parameter int DEPTH  = lapedge_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lapedge_front.sv
// Front end: accepts pixels, tracks raster position, line stores and window.
module lapedge_front #(
  parameter int MAX_WIDTH = lapedge_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [lapedge_pkg::CFG_W-1:0]     cfg_data,
  lapedge_in_if.sink                        pixels,
  input  logic [lapedge_pkg::QCNT_W-1:0]    q_level,
  output lapedge_pkg::q_slot_t              q_push
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int POS_W = ((COL_W > lapedge_pkg::CFG_W) ? COL_W : lapedge_pkg::CFG_W) + 1;
  localparam int CNT_W = lapedge_pkg::QCNT_W + 1;

  logic [lapedge_pkg::CFG_W-1:0] img_w;
  logic [lapedge_pkg::CFG_W-1:0] img_h;
  logic [COL_W-1:0]              col;
  logic [lapedge_pkg::ROW_W-1:0] row;

  logic                          a_valid;
  lapedge_pkg::pix_t             a_pix;
  logic [COL_W-1:0]              a_addr;
  lapedge_pkg::class_t           a_class;
  logic                          a_fwd;
  lapedge_pkg::pix_t             fwd_top;
  lapedge_pkg::pix_t             fwd_mid;

  lapedge_pkg::col_t             win1;
  lapedge_pkg::col_t             win2;

  logic                          accept;
  lapedge_pkg::pix_t             pix_in;
  lapedge_pkg::class_t           cls;
  logic                          wrap;
  logic [POS_W-1:0]              colx;
  logic [POS_W-1:0]              rowx;
  logic [POS_W-1:0]              wx;
  logic [POS_W-1:0]              hx;
  logic [POS_W-1:0]              rr;

  logic [2*lapedge_pkg::PIX_W-1:0] rdata;
  lapedge_pkg::pix_t               top_eff;
  lapedge_pkg::pix_t               mid_eff;
  lapedge_pkg::col_t               new_col;

  // Credit check: every request in flight has a queue slot waiting for it.
  assign pixels.ready = ({1'b0, q_level} + CNT_W'(a_valid)) < CNT_W'(lapedge_pkg::QDEPTH);
  assign accept       = pixels.valid && pixels.ready;
  assign pix_in       = (pixels.mode == lapedge_pkg::MODE_PAD) ? '0 : pixels.pixel;

  // The result for a centre comes out one row plus one pixel later, so the
  // centre position and its edge masks follow from the current position alone.
  always_comb begin
    colx = POS_W'(col);
    rowx = POS_W'(row);
    wx   = POS_W'(img_w);
    hx   = POS_W'(img_h);
    rr   = (col != '0) ? rowx + POS_W'(1) : rowx;
    cls.emit   = (rr >= POS_W'(2)) && (rr < hx + POS_W'(2));
    cls.row_lo = (rr >= POS_W'(3));
    cls.row_hi = (rr < hx + POS_W'(1));
    cls.col_lo = (colx >= POS_W'(2)) || ((col == '0) && (wx >= POS_W'(2)));
    cls.col_hi = (col != '0);
    cls.last   = (col == '0) && (rowx == hx + POS_W'(1));
    wrap       = (colx + POS_W'(1)) >= wx;
  end

  lapedge_ram #(
    .WIDTH(2 * lapedge_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (a_valid),
    .waddr(a_addr),
    .wdata({mid_eff, a_pix}),
    .re   (accept),
    .raddr(col),
    .rdata(rdata)
  );

  // With a one-pixel row the same entry is read right as it is being written.
  assign top_eff = a_fwd ? fwd_top : rdata[2*lapedge_pkg::PIX_W-1:lapedge_pkg::PIX_W];
  assign mid_eff = a_fwd ? fwd_mid : rdata[lapedge_pkg::PIX_W-1:0];

  always_comb begin
    new_col.top         = top_eff;
    new_col.mid         = mid_eff;
    new_col.bot         = a_pix;
    q_push.valid        = a_valid && a_class.emit;
    q_push.entry.left   = win1;
    q_push.entry.center = win2;
    q_push.entry.right  = new_col;
    q_push.entry.last   = a_class.last;
    q_push.entry.row_lo = a_class.row_lo;
    q_push.entry.row_hi = a_class.row_hi;
    q_push.entry.col_lo = a_class.col_lo;
    q_push.entry.col_hi = a_class.col_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= lapedge_pkg::clamp_dim(lapedge_pkg::RESET_WIDTH, MAX_WIDTH);
      img_h   <= lapedge_pkg::clamp_dim(lapedge_pkg::RESET_HEIGHT, lapedge_pkg::MAX_HEIGHT);
      col     <= '0;
      row     <= '0;
      a_valid <= 1'b0;
      win1    <= '0;
      win2    <= '0;
    end else begin
      a_valid <= accept;
      if (cfg_we) begin
        unique case (lapedge_pkg::cfg_reg_t'(cfg_index))
          lapedge_pkg::REG_IMAGE_WIDTH: begin
            img_w <= lapedge_pkg::clamp_dim(cfg_data, MAX_WIDTH);
          end
          lapedge_pkg::REG_IMAGE_HEIGHT: begin
            img_h <= lapedge_pkg::clamp_dim(cfg_data, lapedge_pkg::MAX_HEIGHT);
          end
        endcase
        col  <= '0;
        row  <= '0;
        win1 <= '0;
        win2 <= '0;
      end else begin
        if (accept) begin
          priority if (cls.last) begin
            col <= '0;
            row <= '0;
          end else if (wrap) begin
            col <= '0;
            if (row != lapedge_pkg::ROW_SAT) begin
              row <= row + lapedge_pkg::ROW_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        if (a_valid) begin
          if (a_class.last) begin
            win1 <= '0;
            win2 <= '0;
          end else begin
            win1 <= win2;
            win2 <= new_col;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix   <= pix_in;
      a_addr  <= col;
      a_class <= cls;
      a_fwd   <= a_valid && (a_addr == col);
      fwd_top <= mid_eff;
      fwd_mid <= a_pix;
    end
  end

endmodule

// File: rtl/lapedge_queue.sv
// Small FIFO that carries classified neighbourhoods from front to back.
module lapedge_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  lapedge_pkg::q_slot_t           push,
  input  logic                           pop,
  output lapedge_pkg::q_slot_t           head,
  output logic [lapedge_pkg::QCNT_W-1:0] level
);

  lapedge_pkg::q_entry_t           slots [lapedge_pkg::QDEPTH];
  logic [lapedge_pkg::QPTR_W-1:0]  wptr;
  logic [lapedge_pkg::QPTR_W-1:0]  rptr;
  logic [lapedge_pkg::QCNT_W-1:0]  count;

  assign level      = count;
  assign head.valid = (count != '0);
  assign head.entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + lapedge_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + lapedge_pkg::QPTR_W'(1);
      end
      priority if (push.valid && !pop) begin
        count <= count + lapedge_pkg::QCNT_W'(1);
      end else if (pop && !push.valid) begin
        count <= count - lapedge_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wptr] <= push.entry;
    end
  end

endmodule

// File: rtl/lapedge_back.sv
// Back end: masked 3x3 Laplacian sum, clamping and the output register.
module lapedge_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lapedge_pkg::q_slot_t head,
  output logic                 pop,
  lapedge_out_if.source        edges
);

  localparam int SUM_W = lapedge_pkg::SUM_W;

  lapedge_pkg::q_entry_t e;
  logic [SUM_W-1:0]      pos;
  logic [SUM_W-1:0]      neg;
  logic [SUM_W-1:0]      diff;
  lapedge_pkg::pix_t     result;
  logic                  out_valid;
  lapedge_pkg::pix_t     out_value;
  logic                  out_last;

  assign e   = head.entry;
  assign pop = head.valid && (!out_valid || edges.ready);

  always_comb begin
    pos = {e.center.mid, 3'b000};
    neg = SUM_W'(e.left.top   & {lapedge_pkg::PIX_W{e.col_lo && e.row_lo}})
        + SUM_W'(e.left.mid   & {lapedge_pkg::PIX_W{e.col_lo}})
        + SUM_W'(e.left.bot   & {lapedge_pkg::PIX_W{e.col_lo && e.row_hi}})
        + SUM_W'(e.center.top & {lapedge_pkg::PIX_W{e.row_lo}})
        + SUM_W'(e.center.bot & {lapedge_pkg::PIX_W{e.row_hi}})
        + SUM_W'(e.right.top  & {lapedge_pkg::PIX_W{e.col_hi && e.row_lo}})
        + SUM_W'(e.right.mid  & {lapedge_pkg::PIX_W{e.col_hi}})
        + SUM_W'(e.right.bot  & {lapedge_pkg::PIX_W{e.col_hi && e.row_hi}});
    diff = pos - neg;
    priority if (neg >= pos) begin
      result = '0;
    end else if (diff > SUM_W'(255)) begin
      result = '1;
    end else begin
      result = diff[lapedge_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_value <= result;
      out_last  <= e.last;
    end
  end

  assign edges.valid      = out_valid;
  assign edges.edge_value = out_value;
  assign edges.last_pixel = out_last;

endmodule

// File: rtl/laplacian_edge_filter_3x3_unit.sv
// Top level of the streaming 3x3 Laplacian edge filter.
//
// Pixels arrive in raster order on the pixels channel (mode 0 = image pixel,
// mode 1 = padding). After an image the host sends image_width + 1 padding
// requests to flush the last row. Results leave on the edges channel, one per
// pixel of the image, the last one marked with last_pixel.
// A result is produced when the request one row plus one pixel after its centre
// is accepted. The block takes one request per clock while pixels.ready is high:
// the line store RAM is read for the new column and written back in the next
// cycle, with a bypass for one-pixel rows. Configuration writes (index 0 =
// width, index 1 = height) restart the frame, as does the final pixel of an
// image; the user must make them only while the block is idle, which it does
// not enforce. Reset sets the size to 640 x 480 and clears position and window;
// the line store is not cleared, since entries never written lie outside the
// image. When the receiver stalls, the output register holds its result and a
// four-entry queue absorbs work in flight; pixels.ready drops once it is full.
module laplacian_edge_filter_3x3_unit #(
  parameter int MAX_WIDTH = lapedge_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lapedge_pkg::CFG_W-1:0] cfg_data,
  lapedge_in_if.sink                    pixels,
  lapedge_out_if.source                 edges
);

  lapedge_pkg::q_slot_t            q_push;
  lapedge_pkg::q_slot_t            q_head;
  logic                            q_pop;
  logic [lapedge_pkg::QCNT_W-1:0]  q_level;

  lapedge_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pixels),
    .q_level  (q_level),
    .q_push   (q_push)
  );

  lapedge_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .head (q_head),
    .level(q_level)
  );

  lapedge_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (q_head),
    .pop  (q_pop),
    .edges(edges)
  );

`ifndef SYNTHESIS
  // The credit check in the front must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> (q_level != lapedge_pkg::QCNT_W'(lapedge_pkg::QDEPTH)))
    else $error("queue written while full");

  // After the final pixel the frame restarts, so the next request has no centre.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (q_push.valid && q_push.entry.last) |=> !q_push.valid)
    else $error("result pushed right after the final pixel");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the streaming 3x3 Laplacian edge filter.
module tb_top;

  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1230;
  localparam int MAX_ERR_LINES = 50;
  localparam longint RUN_LIMIT = 40_000_000;
  localparam int LS_AW = $clog2(lapedge_pkg::MAX_WIDTH_DEF);

  typedef struct {
    logic              mode;
    lapedge_pkg::pix_t pixel;
  } pixel_req_t;

  typedef struct {
    lapedge_pkg::pix_t edge_value;
    logic              last_pixel;
  } edge_res_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [0:0]                   cfg_index = '0;
  logic [lapedge_pkg::CFG_W-1:0] cfg_data = '0;

  lapedge_in_if  pixels_if ();
  lapedge_out_if edges_if ();

  laplacian_edge_filter_3x3_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if),
    .edges     (edges_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_req_t pixel_req_q[$];
  edge_res_t  edge_expect_q[$];
  int         items_queued = 0;
  int         items_accepted = 0;
  int         results_seen = 0;
  int         error_count = 0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;

  // Shadow of the filter state, updated on every accepted request.
  logic [lapedge_pkg::CFG_W-1:0] img_width;
  logic [lapedge_pkg::CFG_W-1:0] img_height;
  lapedge_pkg::pix_t             line_upper [lapedge_pkg::MAX_WIDTH_DEF];
  lapedge_pkg::pix_t             line_lower [lapedge_pkg::MAX_WIDTH_DEF];
  lapedge_pkg::pix_t             win [3][3];
  int unsigned                   in_col;
  logic [lapedge_pkg::ROW_W-1:0] in_row;

  task automatic flag_error(string msg);
    if (error_count < MAX_ERR_LINES) $display("[%0t] ERROR %s", $time, msg);
    error_count++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lapedge_pkg::pix_t rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return lapedge_pkg::pix_t'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned clamp_size(logic [lapedge_pkg::CFG_W-1:0] val, int limit);
    if (val == '0) return 1;
    if (int'(val) > limit) return limit;
    return 32'(val);
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = '0;
    win = '{default: '0};
  endfunction

  function automatic void reset_filter_state();
    img_width  = lapedge_pkg::RESET_WIDTH;
    img_height = lapedge_pkg::RESET_HEIGHT;
    line_upper = '{default: '0};
    line_lower = '{default: '0};
    restart_frame();
  endfunction

  // Advances the shadow state by one request; returns 1 when it completes a centre.
  function automatic bit laplace_step(input logic mode, input lapedge_pkg::pix_t pixel_in,
                                      output edge_res_t res);
    int unsigned       w, h, ic;
    lapedge_pkg::pix_t v, top, mid;
    logic [LS_AW-1:0]  ia;
    logic [1:0]        c, r;
    int                cr, cc, acc, col, rw;
    w = clamp_size(img_width, lapedge_pkg::MAX_WIDTH_DEF);
    h = clamp_size(img_height, lapedge_pkg::MAX_HEIGHT);
    v = (mode == lapedge_pkg::MODE_PAD) ? lapedge_pkg::pix_t'(0) : pixel_in;
    ic = in_col;
    res.edge_value = '0;
    res.last_pixel = 1'b0;
    if (ic >= w) ic = w - 1;
    ia = LS_AW'(ic);
    top = line_upper[ia];
    mid = line_lower[ia];
    line_upper[ia] = mid;
    line_lower[ia] = v;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = '{top, mid, v};
    // In raster order the centre sits one row plus one pixel behind the input.
    if (ic >= 1) begin
      cr = int'(in_row) - 1;
      cc = int'(ic) - 1;
    end else begin
      cr = int'(in_row) - 2;
      cc = int'(w) - 1;
    end
    if (ic + 1 >= w) begin
      in_col = 0;
      if (in_row != lapedge_pkg::ROW_SAT) in_row = in_row + lapedge_pkg::ROW_W'(1);
    end else begin
      in_col = ic + 1;
    end
    if (cr < 0 || cr >= int'(h)) return 1'b0;
    acc = 0;
    for (c = 2'd0; c < 2'd3; c++) begin
      col = cc - 1 + int'(c);
      if (col >= 0 && col < int'(w)) begin
        for (r = 2'd0; r < 2'd3; r++) begin
          rw = cr - 1 + int'(r);
          if (rw >= 0 && rw < int'(h)) begin
            if (r == 2'd1 && c == 2'd1) acc += 8 * int'(win[c][r]);
            else acc -= int'(win[c][r]);
          end
        end
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    res.edge_value = lapedge_pkg::pix_t'(acc);
    res.last_pixel = (cr == int'(h) - 1) && (cc == int'(w) - 1);
    if (res.last_pixel) restart_frame();
    return 1'b1;
  endfunction

  // Register writes and accepted requests feed the shadow state.
  always @(posedge clk) begin
    edge_res_t res;
    if (rst) begin
      reset_filter_state();
    end else begin
      if (cfg_we) begin
        if (lapedge_pkg::cfg_reg_t'(cfg_index) == lapedge_pkg::REG_IMAGE_WIDTH)
          img_width = cfg_data;
        else
          img_height = cfg_data;
        restart_frame();
      end
      if (pixels_if.valid && pixels_if.ready) begin
        items_accepted++;
        if (laplace_step(pixels_if.mode, pixels_if.pixel, res)) edge_expect_q.push_back(res);
      end
    end
  end

  always @(posedge clk) begin
    pixel_req_t req;
    if (rst) begin
      pixels_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!pixels_if.valid || pixels_if.ready) begin
      if (send_gap != 0 && !calm) begin
        pixels_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_req_q.size() != 0) begin
        req = pixel_req_q.pop_front();
        pixels_if.valid <= 1'b1;
        pixels_if.mode  <= req.mode;
        pixels_if.pixel <= req.pixel;
        send_gap <= calm ? 0 : idle_len();
      end else begin
        pixels_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      edges_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0 && !calm) begin
      edges_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      edges_if.ready <= 1'b1;
      stall_left <= (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    end
  end

  always @(posedge clk) begin
    edge_res_t want;
    if (!rst && edges_if.valid && edges_if.ready) begin
      if (edge_expect_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request owing one", results_seen));
      end else begin
        want = edge_expect_q.pop_front();
        if (edges_if.edge_value !== want.edge_value)
          flag_error($sformatf("result %0d: edge_value %0d, expected %0d", results_seen,
                               edges_if.edge_value, want.edge_value));
        if (edges_if.last_pixel !== want.last_pixel)
          flag_error($sformatf("result %0d: last_pixel %b, expected %b", results_seen,
                               edges_if.last_pixel, want.last_pixel));
      end
      results_seen++;
    end
  end

  task automatic push_item(logic mode, lapedge_pkg::pix_t pixel);
    pixel_req_t req;
    req.mode = mode;
    req.pixel = pixel;
    pixel_req_q.push_back(req);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || edge_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lapedge_pkg::cfg_reg_t idx, logic [lapedge_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_image(int w, int h, bit can_abort, output bit aborted);
    int total, cut, k;
    total = w * (h + 1) + 1;
    cut = (can_abort && $urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
    for (k = 0; k < cut; k++) begin
      if (k < w * h)
        push_item(($urandom_range(0, 19) == 0) ? lapedge_pkg::MODE_PAD : ~lapedge_pkg::MODE_PAD,
                  rand_pixel());
      else if ($urandom_range(0, 5) == 0)
        push_item(~lapedge_pkg::MODE_PAD, rand_pixel());
      else
        push_item(lapedge_pkg::MODE_PAD, lapedge_pkg::pix_t'($urandom_range(0, 255)));
    end
    aborted = (cut != total);
  endtask

  initial begin
    int                w, h, sel, nframes, random_start;
    bit                aborted, first;
    lapedge_pkg::pix_t ring [9];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Tiny images: a dark centre in a bright ring, then a bright centre in a dark ring
    // with a padding request inside the image. The flush of the first image mixes
    // padding with pixels that lie past the image.
    write_reg(lapedge_pkg::REG_IMAGE_WIDTH, 12'd3);
    write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, 12'd3);
    ring = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    foreach (ring[i]) push_item(~lapedge_pkg::MODE_PAD, ring[i]);
    push_item(lapedge_pkg::MODE_PAD, 8'hFF);
    push_item(lapedge_pkg::MODE_PAD, 8'h00);
    push_item(~lapedge_pkg::MODE_PAD, 8'd17);
    push_item(~lapedge_pkg::MODE_PAD, 8'd200);
    ring = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    foreach (ring[i])
      push_item((i == 7) ? lapedge_pkg::MODE_PAD : ~lapedge_pkg::MODE_PAD,
                (i == 7) ? 8'hAA : ring[i]);
    repeat (4) push_item(lapedge_pkg::MODE_PAD, 8'h55);
    wait_idle();

    // Zero sizes saturate to a single pixel.
    write_reg(lapedge_pkg::REG_IMAGE_WIDTH, 12'd0);
    write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, 12'd0);
    push_item(~lapedge_pkg::MODE_PAD, 8'd200);
    push_item(lapedge_pkg::MODE_PAD, 8'd0);
    push_item(lapedge_pkg::MODE_PAD, 8'd0);
    wait_idle();

    // Oversized width, cut off early in the first row; the next write restarts it.
    write_reg(lapedge_pkg::REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, 12'd1);
    calm = 1'b1;
    repeat (64) push_item(~lapedge_pkg::MODE_PAD, lapedge_pkg::pix_t'($urandom_range(0, 255)));
    repeat (6) push_item(lapedge_pkg::MODE_PAD, 8'd0);
    wait_idle();
    calm = 1'b0;

    // Tallest image, one pixel wide, also left unfinished.
    write_reg(lapedge_pkg::REG_IMAGE_WIDTH, 12'd1);
    write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
    repeat (24) push_item(~lapedge_pkg::MODE_PAD, rand_pixel());
    wait_idle();

    random_start = items_queued;
    first = 1'b1;
    w = 1;
    h = 1;
    while (items_queued - random_start < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      sel = first ? 2 : $urandom_range(0, 3);
      first = 1'b0;
      if (sel != 1) begin
        w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        write_reg(lapedge_pkg::REG_IMAGE_WIDTH, lapedge_pkg::CFG_W'(w));
      end
      if (sel != 0) begin
        h = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, lapedge_pkg::CFG_W'(h));
      end
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        queue_image(w, h, 1'b1, aborted);
        if (aborted) break;
      end
    end

    wait_idle();
    calm = 1'b0;
    if (edge_expect_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", edge_expect_q.size()));
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[%0t] timeout: %0d requests accepted, %0d results seen", $time,
             items_accepted, results_seen);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
